// ----- src/target_in_view_detector_macros.svh -----
// ----------------------------------------------------------------------------
// Target in view detector assertion macros
// Shared property forms for the concurrent checks of the detector.
// ----------------------------------------------------------------------------
`ifndef TARGET_IN_VIEW_DETECTOR_MACROS_SVH
`define TARGET_IN_VIEW_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tvd_pkg.sv -----
// ----------------------------------------------------------------------------
// Target in view detector package
// Shared constants, command and status types, and the arctangent table.
// ----------------------------------------------------------------------------
package tvd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;
    localparam int DW = 45;
    localparam int ZW = 34;
    localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;
    localparam logic [15:0] GAIN_Q16 = 16'd39797;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_MIN_RANGE = 3'd2;
    localparam logic [2:0] REG_MAX_RANGE = 3'd3;
    localparam logic [2:0] REG_HALF_VIEW = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_QMUL,
        OP_PVINIT,
        OP_VSTEP,
        OP_PSTORE,
        OP_MULX,
        OP_MULY,
        OP_RINIT,
        OP_RSTEP,
        OP_TVINIT,
        OP_DLO,
        OP_DHI,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic pose_valid;
        logic out_full;
    } status_t;

    function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- src/tvd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Target in view detector controller
// Sequences the quaternion products, the CORDIC steps and the result load.
// ----------------------------------------------------------------------------
module tvd_ctrl
    import tvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_QMUL,
        S_PVINIT,
        S_PVSTEP,
        S_PSTORE,
        S_TMULX,
        S_TMULY,
        S_RINIT,
        S_RSTEP,
        S_TVINIT,
        S_TVSTEP,
        S_DLO,
        S_DHI,
        S_DONE
    } state_t;

    localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] QLAST = STEP_W'(3);

    state_t state_reg;
    logic [STEP_W-1:0] cnt_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.step = cnt_reg;
        case (state_reg)
            S_IDLE:   cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
            S_QMUL:   cmd.op = OP_QMUL;
            S_PVINIT: cmd.op = OP_PVINIT;
            S_PVSTEP: cmd.op = OP_VSTEP;
            S_PSTORE: cmd.op = OP_PSTORE;
            S_TMULX:  cmd.op = OP_MULX;
            S_TMULY:  cmd.op = OP_MULY;
            S_RINIT:  cmd.op = OP_RINIT;
            S_RSTEP:  cmd.op = OP_RSTEP;
            S_TVINIT: cmd.op = OP_TVINIT;
            S_TVSTEP: cmd.op = OP_VSTEP;
            S_DLO:    cmd.op = OP_DLO;
            S_DHI:    cmd.op = OP_DHI;
            S_DONE:   cmd.op = status.out_full ? OP_NONE : OP_LOAD;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    cnt_reg <= '0;
                    if (!status.func)
                    begin
                        state_reg <= S_QMUL;
                    end
                    else if (status.pose_valid)
                    begin
                        state_reg <= S_TMULX;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_QMUL:
                begin
                    if (cnt_reg == QLAST)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_PVINIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PVINIT: state_reg <= S_PVSTEP;
                S_PVSTEP:
                begin
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_PSTORE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PSTORE: state_reg <= S_IDLE;
                S_TMULX:  state_reg <= S_TMULY;
                S_TMULY:  state_reg <= S_RINIT;
                S_RINIT:  state_reg <= S_RSTEP;
                S_RSTEP:
                begin
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_TVINIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_TVINIT: state_reg <= S_TVSTEP;
                S_TVSTEP:
                begin
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_DLO;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DLO: state_reg <= S_DHI;
                S_DHI: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!status.out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/tvd_datapath.sv -----
// ----------------------------------------------------------------------------
// Target in view detector datapath
// Registers, shared CORDIC stage, multipliers and the result register.
// ----------------------------------------------------------------------------
module tvd_datapath
    import tvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               detected,
    output logic signed [31:0] offset_x,
    output logic signed [31:0] offset_y,
    output logic [31:0]        range_out,
    output logic signed [15:0] bearing_out
);

    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sh40000000);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sh80000000);

    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [31:0] min_range_reg, max_range_reg;
    logic [14:0] half_view_reg;

    logic func_reg;
    logic signed [31:0] in_x_reg, in_y_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic signed [31:0] robot_x_reg, robot_y_reg;
    logic [15:0] robot_yaw_reg;
    logic pose_valid_reg;

    logic signed [32:0] acc_n_reg, acc_d_reg;
    logic signed [DW-1:0] x_reg, y_reg, lx_reg, ly_reg;
    logic signed [ZW-1:0] z_reg;
    logic zero_reg;
    logic [37:0] plo_reg;
    logic [36:0] dist_reg;

    logic out_valid_reg;
    logic det_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic [31:0] rng_reg;
    logic [15:0] brg_reg;

    logic signed [15:0] qa, qb;
    logic signed [31:0] qp;
    logic signed [33:0] n_val;
    logic signed [34:0] d_val;
    logic signed [DW-1:0] xs, ys, vx, vy;
    logic signed [ZW-1:0] at;
    logic signed [32:0] dx;
    logic signed [57:0] gprod;
    logic signed [31:0] a32;
    logic signed [ZW-1:0] zr;
    logic [37:0] phi;
    logic [60:0] dsum;
    logic [31:0] ang;
    logic [31:0] ang_r;
    logic signed [16:0] bs, babs;
    logic [31:0] lo, hi;
    logic front, inr, inv;

    function automatic logic [31:0] sat32(input logic signed [DW:0] v);
        logic signed [DW:0] t;
        t = (v + (DW+1)'(128)) >>> 8;
        if (t > (DW+1)'(64'sh7FFFFFFF))
        begin
            return 32'h7FFFFFFF;
        end
        else if (t < -(DW+1)'(64'sh80000000))
        begin
            return 32'h80000000;
        end
        return t[31:0];
    endfunction

    always_comb
    begin
        case (cmd.step[1:0])
            2'd0: begin qa = qw_reg; qb = qz_reg; end
            2'd1: begin qa = qx_reg; qb = qy_reg; end
            2'd2: begin qa = qy_reg; qb = qy_reg; end
            default: begin qa = qz_reg; qb = qz_reg; end
        endcase
        qp = qa * qb;
        n_val = 34'(acc_n_reg) <<< 1;
        d_val = 35'(64'sh40000000) - (35'(acc_d_reg) <<< 1);

        xs = x_reg >>> cmd.step;
        ys = y_reg >>> cmd.step;
        at = ZW'({2'b00, atan_val(cmd.step)});

        if (cmd.op == OP_PVINIT)
        begin
            vx = DW'(d_val) <<< 8;
            vy = DW'(n_val) <<< 8;
        end
        else
        begin
            vx = x_reg;
            vy = y_reg;
        end

        dx = (cmd.op == OP_MULY) ? (33'(goal_y_reg) - 33'(robot_y_reg))
                                 : (33'(goal_x_reg) - 33'(robot_x_reg));
        gprod = dx * GAIN_Q24;

        a32 = $signed(32'd0 - {robot_yaw_reg, 16'h0000});
        zr = ZW'(a32);

        phi = x_reg[43:22] * GAIN_Q16;
        dsum = {1'b0, phi, 22'h0} + 61'(plo_reg) + 61'(24'h800000);

        ang = zero_reg ? 32'h0 : z_reg[31:0];
        ang_r = ang + 32'h00008000;
        bs = 17'($signed(ang_r[31:16]));
        babs = bs[16] ? -bs : bs;
        lo = (min_range_reg < max_range_reg) ? min_range_reg : max_range_reg;
        hi = (min_range_reg < max_range_reg) ? max_range_reg : min_range_reg;
        front = lx_reg > 0;
        inr = (dist_reg >= 37'(lo)) && (dist_reg <= 37'(hi));
        inv = babs <= 17'(half_view_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= 32'sd98304;
            goal_y_reg <= 32'sd65536;
            min_range_reg <= 32'd3277;
            max_range_reg <= 32'd131072;
            half_view_reg <= 15'd6372;
            robot_x_reg <= '0;
            robot_y_reg <= '0;
            robot_yaw_reg <= '0;
            pose_valid_reg <= 1'b0;
            func_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GOAL_X:    goal_x_reg <= cfg_data;
                    REG_GOAL_Y:    goal_y_reg <= cfg_data;
                    REG_MIN_RANGE: min_range_reg <= cfg_data;
                    REG_MAX_RANGE: max_range_reg <= cfg_data;
                    REG_HALF_VIEW: half_view_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CAPTURE: func_reg <= func;
                OP_PSTORE:
                begin
                    robot_x_reg <= in_x_reg;
                    robot_y_reg <= in_y_reg;
                    robot_yaw_reg <= ang_r[31:16];
                    pose_valid_reg <= 1'b1;
                end
                OP_LOAD: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                in_x_reg <= pos_x;
                in_y_reg <= pos_y;
                qw_reg <= quat_w;
                qx_reg <= quat_x;
                qy_reg <= quat_y;
                qz_reg <= quat_z;
            end
            OP_QMUL:
            begin
                case (cmd.step[1:0])
                    2'd0: acc_n_reg <= 33'(qp);
                    2'd1: acc_n_reg <= acc_n_reg + 33'(qp);
                    2'd2: acc_d_reg <= 33'(qp);
                    default: acc_d_reg <= acc_d_reg + 33'(qp);
                endcase
            end
            OP_PVINIT, OP_TVINIT:
            begin
                if (cmd.op == OP_TVINIT)
                begin
                    lx_reg <= x_reg;
                    ly_reg <= y_reg;
                end
                zero_reg <= (vx == 0) && (vy == 0);
                if (vx < 0)
                begin
                    x_reg <= -vx;
                    y_reg <= -vy;
                    z_reg <= HALF;
                end
                else
                begin
                    x_reg <= vx;
                    y_reg <= vy;
                    z_reg <= '0;
                end
            end
            OP_VSTEP:
            begin
                if (!y_reg[DW-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
            end
            OP_MULX: x_reg <= DW'(gprod >>> 16);
            OP_MULY: y_reg <= DW'(gprod >>> 16);
            OP_RINIT:
            begin
                if (zr > QUARTER)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= zr - HALF;
                end
                else if (zr < -QUARTER)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= zr + HALF;
                end
                else
                begin
                    z_reg <= zr;
                end
            end
            OP_RSTEP:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            OP_DLO: plo_reg <= 38'(x_reg[21:0] * GAIN_Q16);
            OP_DHI: dist_reg <= dsum[60:24];
            OP_LOAD:
            begin
                if (pose_valid_reg)
                begin
                    det_reg <= front && inr && inv;
                    ox_reg <= sat32((DW+1)'(lx_reg));
                    oy_reg <= sat32((DW+1)'(ly_reg));
                    rng_reg <= (|dist_reg[36:32]) ? 32'hFFFFFFFF : dist_reg[31:0];
                    brg_reg <= ang_r[31:16];
                end
                else
                begin
                    det_reg <= 1'b0;
                    ox_reg <= '0;
                    oy_reg <= '0;
                    rng_reg <= '0;
                    brg_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    assign status.func = func_reg;
    assign status.pose_valid = pose_valid_reg;
    assign status.out_full = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign detected = det_reg;
    assign offset_x = ox_reg;
    assign offset_y = oy_reg;
    assign range_out = rng_reg;
    assign bearing_out = brg_reg;

endmodule

// ----- src/target_in_view_detector.sv -----
// ----------------------------------------------------------------------------
// Target in view detector
// Stores the robot pose and yaw, and on each tick tests whether the goal is
// in front, inside the distance window and inside the half field of view.
//
//   Channel   Handshake                 Payload
//   in        in_valid / in_ready       func, pos_x, pos_y, quat_w..quat_z
//   out       out_valid / out_ready     detected, offset_x/y, range_out, bearing_out
//   cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Pose and tick items share a single CORDIC stage, which runs one step per cycle.
// A tick before any pose skips the CORDIC and reports zeros.
// The next item is accepted while a result waits in the output register.
// Reset is asynchronous, clears the pose and out_valid, and sets the config registers to defaults.
// ----------------------------------------------------------------------------
`include "target_in_view_detector_macros.svh"

module target_in_view_detector
    import tvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               detected,
    output logic signed [31:0] offset_x,
    output logic signed [31:0] offset_y,
    output logic [31:0]        range_out,
    output logic signed [15:0] bearing_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cmd_t cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tvd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tvd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .detected    (detected),
        .offset_x    (offset_x),
        .offset_y    (offset_y),
        .range_out   (range_out),
        .bearing_out (bearing_out)
    );

    `TVD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `TVD_ASSERT_SAME(a_load_needs_room, cmd.op == OP_LOAD, !status.out_full, "load over full output")
    `TVD_ASSERT_NEXT(a_out_drains, out_valid && out_ready && cmd.op != OP_LOAD, !out_valid, "result repeated")

endmodule
